@@ hdl/efla_pkg.sv @@
// Shared types and constants of the free-list allocator.
`timescale 1ns / 1ps
package efla_pkg;
   localparam int unsigned HEAP_BYTES = 1024;
   localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
   localparam int unsigned ADDR_W = $clog2(HEAP_WORDS);
   localparam int unsigned OFF_W = $clog2(HEAP_BYTES);
   localparam int unsigned STEP_W = ADDR_W + 1;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_CONS  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOMEM    = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   // Memory port bundle from the engine to the heap RAM.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_cmd_type;
endpackage

@@ hdl/explicit_free_list_allocator_top.sv @@
// Top level of the explicit free-list first-fit heap allocator.
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (lsb first)                 | tuser
// req     | in  | req_type[1:0] req_size[13:2] off[23:14]  | none
// rsp     | out | status[1:0] alloc_offset[11:2]           | none
//
// Heap walks: allocate follows the free list node by node, and consolidate
//   visits each heap block in address order. All heap accesses go through
//   the single read and write port of the RAM.
// Reset: a clearing pass over all HEAP_WORDS (256) words rebuilds the initial
//   heap; no item is accepted meanwhile.
// Stalls: one item at a time; the result waits in a register until taken.
module explicit_free_list_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // req_type, req_size, payload_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status, alloc_offset
);
   efla_pkg::mem_cmd_type cmd;
   logic [31:0] rdata;
   logic        busy, clearing, done;
   logic [1:0]  status;
   logic [efla_pkg::OFF_W-1:0] alloc_off;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic        start;

   // Accept only when idle and the result slot is empty.
   assign req_tready = !busy && !rsp_valid_ff;
   assign start      = req_tvalid && req_tready;

   efla_engine u_engine (
      .clock(clock), .reset(reset), .start(start),
      .op(req_tdata[1:0]), .size(req_tdata[13:2]), .offset(req_tdata[23:14]),
      .busy(busy), .clearing(clearing), .done(done), .status(status),
      .alloc_off(alloc_off), .cmd(cmd), .rdata(rdata)
   );

   efla_ram #(.WIDTH(32), .DEPTH(efla_pkg::HEAP_WORDS)) u_heap (
      .clock(clock), .we(cmd.we), .waddr(cmd.waddr), .wdata(cmd.wdata),
      .raddr(cmd.raddr), .rdata(rdata)
   );

   // Hold the result until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_data_ff <= {4'd0, alloc_off, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready) else $error("accept during clear");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff) else $error("result overwrite");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("start lost");
endmodule

@@ hdl/efla_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module efla_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/efla_engine.sv @@
// Sequencer that runs allocate, free, consolidate and the clearing pass.
`timescale 1ns / 1ps
module efla_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    op,
   input  logic [11:0]                   size,
   input  logic [efla_pkg::OFF_W-1:0]    offset,
   output logic                          busy,
   output logic                          clearing,
   output logic                          done,
   output logic [1:0]                    status,
   output logic [efla_pkg::OFF_W-1:0]    alloc_off,
   output efla_pkg::mem_cmd_type         cmd,
   input  logic [31:0]                   rdata
);
   localparam int unsigned AW = efla_pkg::ADDR_W;
   localparam int unsigned OW = efla_pkg::OFF_W;
   localparam int unsigned SW = efla_pkg::STEP_W;
   localparam logic [31:0] HB32 = 32'(efla_pkg::HEAP_BYTES);
   localparam logic [SW-1:0] HW = SW'(efla_pkg::HEAP_WORDS);

   localparam logic [1:0] REQ_ALLOC_C = efla_pkg::REQ_ALLOC;
   localparam logic [1:0] REQ_FREE_C  = efla_pkg::REQ_FREE;
   localparam logic [1:0] REQ_CONS_C  = efla_pkg::REQ_CONS;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_HDR, S_A_LNK, S_A_DEC, S_A_W1, S_A_W2, S_A_W3, S_A_W4,
      S_F_RD, S_F_CHK, S_F_W2,
      S_C_RD, S_C_SKIP, S_C_MERGE, S_C_W1, S_C_W2, S_C_W3,
      S_RESP
   } state_type;

   state_type         state_ff;
   logic [SW-1:0]     cnt_ff;       // clear index, walk steps
   logic [AW-1:0]     cur_ff, prev_ff;
   logic              at_head_ff;
   logic [31:0]       hdr_ff, lnk_ff;
   logic [AW-1:0]     head_ff;
   logic              nonempty_ff;
   logic [1:0]        status_ff;
   logic [OW-1:0]     aoff_ff;
   logic [SW-1:0]     pos_ff;       // consolidate scan position, may reach end
   logic [AW-1:0]     start_ff, cprev_ff;
   logic              first_ff;
   logic [31:0]       sum_ff;
   logic [11:0]       size_ff;      // request fields held for the whole item
   logic [OW-1:0]     off_ff;
   logic [11:0]       sz;
   logic [OW-1:0]     ofs;
   logic [31:0]       rounded;
   logic [31:0]       meta;
   logic              size_bad;
   logic              lnk_valid;
   logic [31:0]       lnk_off;
   logic [AW-1:0]     lnk_word;
   logic [31:0]       rbytes;
   logic [SW+30:0]    pos_next;
   logic              pos_end;
   logic [AW-1:0]     nfree_w;
   logic [AW-1:0]     hidx;
   logic              free_bad;

   always_comb begin
      sz        = (state_ff == S_IDLE) ? size : size_ff;
      ofs       = (state_ff == S_IDLE) ? offset : off_ff;
      rounded   = (32'(sz) + 32'd3) & 32'hffff_fffc;
      meta      = rounded + 32'd1;
      size_bad  = (sz == 12'd0) || (32'(sz) > HB32) || !nonempty_ff;
      lnk_off   = rdata - 32'd4;
      lnk_valid = (rdata != 32'd0) && (lnk_off[1:0] == 2'b00) && (lnk_off < HB32);
      lnk_word  = lnk_off[AW+1:2];
      rbytes    = rdata & 32'hffff_fffc;
      pos_next  = (SW+31)'(pos_ff) + (SW+31)'(1) + (SW+31)'(rbytes[31:2]);
      pos_end   = pos_next >= (SW+31)'(HW);
      nfree_w   = cur_ff + rounded[AW+1:2] + AW'(1);
      hidx      = ofs[OW-1:2] - AW'(1);
      free_bad  = (ofs[1:0] != 2'b00) || (ofs < OW'(4))
                  || (ofs[OW-1:2] == {AW{1'b1}});
   end

   // Memory command for the current state.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.we    = 1'b1;
            cmd.waddr = cnt_ff[AW-1:0];
            cmd.wdata = (cnt_ff == '0) ? HB32 - 32'd4 : 32'd0;
         end
         S_IDLE: begin
            cmd.raddr = (op == REQ_ALLOC_C) ? head_ff
                      : (op == REQ_FREE_C) ? hidx : AW'(0);
         end
         S_A_HDR:   cmd.raddr = cur_ff + AW'(1);
         S_A_LNK:   cmd.raddr = lnk_word;
         S_A_DEC:   cmd.raddr = cur_ff + AW'(1);
         S_A_W1: begin
            cmd.we    = 1'b1;
            cmd.waddr = nfree_w;
            cmd.wdata = hdr_ff - rounded - 32'd4;
         end
         S_A_W2: begin
            cmd.we    = 1'b1;
            cmd.waddr = nfree_w + AW'(1);
            cmd.wdata = lnk_ff;
         end
         S_A_W3: begin
            cmd.we    = 1'b1;
            cmd.waddr = cur_ff;
            cmd.wdata = (32'(sz) + 32'd8 <= hdr_ff) ? meta : (hdr_ff | 32'd1);
         end
         S_A_W4: begin
            cmd.we    = 1'b1;
            cmd.waddr = prev_ff + AW'(1);
            cmd.wdata = (32'(sz) + 32'd8 <= hdr_ff)
                      ? {{(30-AW){1'b0}}, nfree_w, 2'b00} + 32'd4 : lnk_ff;
         end
         S_F_CHK: begin
            cmd.we    = !rdata[0] ? 1'b0 : 1'b1;
            cmd.waddr = hidx;
            cmd.wdata = rdata & 32'hffff_fffe;
         end
         S_F_W2: begin
            cmd.we    = 1'b1;
            cmd.waddr = ofs[OW-1:2];
            cmd.wdata = nonempty_ff ? {{(30-AW){1'b0}}, head_ff, 2'b00} + 32'd4 : 32'd0;
         end
         S_C_RD:    cmd.raddr = pos_ff[AW-1:0];
         S_C_SKIP:  cmd.raddr = pos_next[AW-1:0];
         S_C_MERGE: cmd.raddr = pos_next[AW-1:0];
         S_C_W1: begin
            cmd.we    = 1'b1;
            cmd.waddr = cprev_ff + AW'(1);
            cmd.wdata = {{(30-AW){1'b0}}, start_ff, 2'b00} + 32'd4;
         end
         S_C_W2: begin
            cmd.we    = 1'b1;
            cmd.waddr = start_ff;
            cmd.wdata = sum_ff - 32'd4;
         end
         S_C_W3: begin
            cmd.we    = 1'b1;
            cmd.waddr = start_ff + AW'(1);
            cmd.wdata = 32'd0;
            cmd.raddr = pos_ff[AW-1:0];
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         cnt_ff      <= '0;
         head_ff     <= '0;
         nonempty_ff <= 1'b1;
         status_ff   <= efla_pkg::ST_DONE;
         aoff_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + SW'(1);
               if (cnt_ff == HW - SW'(1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  status_ff <= efla_pkg::ST_DONE;
                  aoff_ff   <= '0;
                  size_ff   <= size;
                  off_ff    <= offset;
                  unique case (op)
                     REQ_ALLOC_C: begin
                        if (size_bad) begin
                           status_ff <= efla_pkg::ST_NOMEM;
                           state_ff  <= S_RESP;
                        end else begin
                           cur_ff     <= head_ff;
                           prev_ff    <= head_ff;
                           at_head_ff <= 1'b1;
                           cnt_ff     <= '0;
                           state_ff   <= S_A_HDR;
                        end
                     end
                     REQ_FREE_C: begin
                        if (free_bad) begin
                           status_ff <= efla_pkg::ST_BAD_FREE;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_F_CHK;
                        end
                     end
                     REQ_CONS_C: begin
                        nonempty_ff <= 1'b0;
                        head_ff     <= '0;
                        first_ff    <= 1'b1;
                        pos_ff      <= '0;
                        state_ff    <= S_C_RD;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_A_HDR: begin
               hdr_ff   <= rdata;
               state_ff <= S_A_LNK;
            end
            S_A_LNK: begin
               lnk_ff <= rdata;
               if (hdr_ff <= meta && lnk_valid && cnt_ff < HW) begin
                  prev_ff    <= cur_ff;
                  cur_ff     <= lnk_word;
                  at_head_ff <= 1'b0;
                  cnt_ff     <= cnt_ff + SW'(1);
                  state_ff   <= S_A_DEC;
               end else if (hdr_ff <= meta) begin
                  status_ff <= efla_pkg::ST_NOMEM;
                  state_ff  <= S_RESP;
               end else begin
                  aoff_ff <= {cur_ff, 2'b00} + OW'(4);
                  if (32'(sz) + 32'd8 <= hdr_ff) begin
                     state_ff <= S_A_W1;
                  end else begin
                     state_ff <= S_A_W3;
                  end
               end
            end
            S_A_DEC: begin
               // Header of the next node arrives; link read issued now.
               hdr_ff   <= rdata;
               state_ff <= S_A_LNK;
            end
            S_A_W1: state_ff <= S_A_W2;
            S_A_W2: state_ff <= S_A_W3;
            S_A_W3: begin
               if (at_head_ff) begin
                  if (32'(sz) + 32'd8 <= hdr_ff) begin
                     head_ff     <= nfree_w;
                     nonempty_ff <= 1'b1;
                  end else begin
                     nonempty_ff <= lnk_ok(lnk_ff);
                     head_ff     <= lnk_ok(lnk_ff) ? lnk_w(lnk_ff) : AW'(0);
                  end
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_A_W4;
               end
            end
            S_A_W4: state_ff <= S_RESP;
            S_F_CHK: begin
               if (!rdata[0]) begin
                  status_ff <= efla_pkg::ST_BAD_FREE;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_F_W2;
               end
            end
            S_F_W2: begin
               head_ff     <= hidx;
               nonempty_ff <= 1'b1;
               state_ff    <= S_RESP;
            end
            S_C_RD: begin
               if (pos_ff >= HW) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_C_SKIP;
               end
            end
            S_C_SKIP: begin
               // rdata is header at pos_ff.
               if (rdata[0]) begin
                  if (pos_end) begin
                     state_ff <= S_RESP;
                  end else begin
                     pos_ff   <= pos_next[SW-1:0];
                     state_ff <= S_C_SKIP;
                  end
               end else begin
                  if (first_ff) begin
                     head_ff     <= pos_ff[AW-1:0];
                     nonempty_ff <= 1'b1;
                  end
                  start_ff <= pos_ff[AW-1:0];
                  sum_ff   <= rbytes + 32'd4;
                  if (pos_end) begin
                     pos_ff   <= HW;
                     state_ff <= first_ff ? S_C_W2 : S_C_W1;
                  end else begin
                     pos_ff   <= pos_next[SW-1:0];
                     state_ff <= S_C_MERGE;
                  end
               end
            end
            S_C_MERGE: begin
               // rdata is header at pos_ff, a possible run member.
               if (rdata[0]) begin
                  state_ff <= first_ff ? S_C_W2 : S_C_W1;
               end else begin
                  sum_ff <= sum_ff + rbytes + 32'd4;
                  if (pos_end) begin
                     pos_ff   <= HW;
                     state_ff <= first_ff ? S_C_W2 : S_C_W1;
                  end else begin
                     pos_ff <= pos_next[SW-1:0];
                  end
               end
            end
            S_C_W1: state_ff <= S_C_W2;
            S_C_W2: begin
               first_ff <= 1'b0;
               state_ff <= S_C_W3;
            end
            S_C_W3: begin
               cprev_ff <= start_ff;
               // Read of pos_ff issued here; header lands next cycle.
               if (pos_ff >= HW) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_C_SKIP;
               end
            end
            S_RESP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   function automatic logic lnk_ok(input logic [31:0] v);
      logic [31:0] o;
      o = v - 32'd4;
      return (v != 32'd0) && (o[1:0] == 2'b00) && (o < HB32);
   endfunction

   function automatic logic [AW-1:0] lnk_w(input logic [31:0] v);
      logic [31:0] o;
      o = v - 32'd4;
      return o[AW+1:2];
   endfunction

   assign busy      = state_ff != S_IDLE;
   assign clearing  = state_ff == S_CLEAR;
   assign done      = state_ff == S_RESP;
   assign status    = status_ff;
   assign alloc_off = aoff_ff;
endmodule

@@ tb/tb_explicit_free_list_allocator_top.sv @@
// Self-checking testbench of the free-list allocator top level.
`timescale 1ns / 1ps
module tb_explicit_free_list_allocator_top;
   localparam int unsigned N_RANDOM = 1400;
   localparam int unsigned MAX_CYCLES = 10000000;

   typedef struct packed {
      logic [9:0]             offset;
      logic [11:0]            size;
      efla_pkg::req_code_type code;
   } heap_req_type;

   typedef struct packed {
      logic [9:0]           alloc_offset;
      efla_pkg::status_type status;
   } heap_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   // shadow heap and free list
   logic [31:0] heap_mem [efla_pkg::HEAP_WORDS];
   logic [31:0] free_head;
   logic        free_valid;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          quiet;
   int unsigned send_gap;
   int unsigned recv_gap;
   int unsigned hold_off;

   explicit_free_list_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // req_type, req_size, payload_offset
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // status, alloc_offset
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] heap_rd(longint unsigned idx);
      return (idx < efla_pkg::HEAP_WORDS) ? heap_mem[idx] : 32'd0;
   endfunction

   function automatic void heap_wr(longint unsigned idx, logic [31:0] v);
      if (idx < efla_pkg::HEAP_WORDS) heap_mem[idx] = v;
   endfunction

   function automatic bit is_alloc(longint unsigned idx);
      logic [31:0] w;
      w = heap_rd(idx);
      return w[0];
   endfunction

   // Decode a link word; null, misaligned or out-of-heap links count as null.
   function automatic bit decode_link(logic [31:0] v, output logic [31:0] off);
      logic [31:0] o;
      off = 32'd0;
      if (v == 32'd0) return 1'b0;
      o = v - 32'd4;
      if (o[1:0] != 2'b00 || o >= efla_pkg::HEAP_BYTES) return 1'b0;
      off = o;
      return 1'b1;
   endfunction

   function automatic void heap_reset_model();
      foreach (heap_mem[i]) heap_mem[i] = 32'd0;
      heap_mem[0] = efla_pkg::HEAP_BYTES - 4;
      free_head = 32'd0;
      free_valid = 1'b1;
   endfunction

   // First fit that skips exact fits; split when the request plus 8 fits.
   function automatic efla_pkg::status_type model_alloc(logic [31:0] size,
                                                        output logic [31:0] payload);
      logic [31:0] rounded, meta, cur, prev, nxt, hdr, steps, nfree, lk;
      bit          at_head;
      at_head = 1'b1;
      payload = 32'd0;
      if (size == 0 || size > efla_pkg::HEAP_BYTES || !free_valid)
         return efla_pkg::ST_NOMEM;
      rounded = (size + 3) & ~32'd3;
      meta = rounded + 1;
      cur = free_head;
      prev = cur;
      steps = 0;
      while (heap_rd(cur / 4) <= meta && decode_link(heap_rd(cur / 4 + 1), nxt)
             && steps < efla_pkg::HEAP_WORDS) begin
         prev = cur;
         cur = nxt;
         at_head = 1'b0;
         steps++;
      end
      hdr = heap_rd(cur / 4);
      if (hdr <= meta) return efla_pkg::ST_NOMEM;
      if (size + 8 <= hdr) begin
         nfree = cur + rounded + 4;
         heap_wr(nfree / 4, hdr - rounded - 4);
         heap_wr(nfree / 4 + 1, heap_rd(cur / 4 + 1));
         heap_wr(cur / 4, meta);
         if (at_head) begin
            free_head = nfree;
            free_valid = 1'b1;
         end else begin
            heap_wr(prev / 4 + 1, nfree + 4);
         end
      end else begin
         lk = heap_rd(cur / 4 + 1);
         heap_wr(cur / 4, hdr | 32'd1);
         if (at_head) begin
            free_valid = decode_link(lk, nxt);
            free_head = free_valid ? nxt : 32'd0;
         end else begin
            heap_wr(prev / 4 + 1, lk);
         end
      end
      payload = cur + 4;
      return efla_pkg::ST_DONE;
   endfunction

   function automatic efla_pkg::status_type model_free(logic [31:0] off);
      logic [31:0] hidx;
      if (off[1:0] != 2'b00 || off < 4 || off / 4 >= efla_pkg::HEAP_WORDS - 1)
         return efla_pkg::ST_BAD_FREE;
      hidx = off / 4 - 1;
      if (!is_alloc(hidx)) return efla_pkg::ST_BAD_FREE;
      heap_wr(hidx, heap_rd(hidx) & ~32'd1);
      heap_wr(off / 4, free_valid ? free_head + 4 : 32'd0);
      free_head = off - 4;
      free_valid = 1'b1;
      return efla_pkg::ST_DONE;
   endfunction

   // Merge adjacent free runs and relink them in address order.
   function automatic void model_consolidate();
      longint unsigned pos, start, prev;
      logic [31:0]     sum, bytes;
      bit              first;
      pos = 0;
      prev = 0;
      first = 1'b1;
      free_valid = 1'b0;
      free_head = 32'd0;
      while (pos < efla_pkg::HEAP_WORDS) begin
         while (pos < efla_pkg::HEAP_WORDS && is_alloc(pos))
            pos += 1 + (heap_rd(pos) & 32'hffff_fffc) / 4;
         if (pos >= efla_pkg::HEAP_WORDS) break;
         if (first) begin
            free_head = pos * 4;
            free_valid = 1'b1;
            first = 1'b0;
         end else begin
            heap_wr(prev + 1, pos * 4 + 4);
         end
         start = pos;
         sum = 0;
         do begin
            bytes = heap_rd(pos) & 32'hffff_fffc;
            sum += bytes + 4;
            pos += 1 + bytes / 4;
         end while (pos < efla_pkg::HEAP_WORDS && !is_alloc(pos));
         heap_wr(start, sum - 4);
         heap_wr(start + 1, 32'd0);
         prev = start;
      end
   endfunction

   function automatic heap_rsp_type predict_rsp(heap_req_type r);
      heap_rsp_type o;
      logic [31:0]  payload;
      o = '0;
      payload = 32'd0;
      case (r.code)
         efla_pkg::REQ_ALLOC: begin
            o.status = model_alloc({20'd0, r.size}, payload);
            if (o.status == efla_pkg::ST_DONE) o.alloc_offset = payload[9:0];
         end
         efla_pkg::REQ_FREE: o.status = model_free({22'd0, r.offset});
         efla_pkg::REQ_CONS: model_consolidate();
         default: o.status = efla_pkg::ST_DONE;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic push_req(logic [1:0] code, int unsigned size, int unsigned off);
      heap_req_type r;
      r.code = efla_pkg::req_code_type'(code);
      r.size = size[11:0];
      r.offset = off[9:0];
      pending_reqs.push_back(r);
   endtask

   // Driver: hold the item until accepted, insert random gaps when not quiet.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         // the current item (if any) leaves at this edge
         if (req_tvalid) expected_rsps.push_back(predict_rsp(heap_req_type'(req_tdata)));
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_tdata <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted down on its own.
   always @(posedge clock) begin
      if (!reset && hold_off != 0) hold_off <= hold_off - 1;
   end

   // Monitor: compare each result with the oldest expectation.
   always @(posedge clock) begin
      heap_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = heap_rsp_type'(rsp_tdata[11:0]);
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.alloc_offset != want.alloc_offset)
                  report_mismatch("alloc_offset", got.alloc_offset, want.alloc_offset);
               if (rsp_tdata[15:12] != 4'd0)
                  report_mismatch("pad bits", rsp_tdata[15:12], 0);
            end
         end
         // long hold-off first, then random bursts of stall
         if (hold_off != 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 9);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned k, pick, idx;
      logic [1:0]  code;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      hold_off = 400;
      heap_reset_model();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: edge sizes, exact fit skip, bad frees, unknown code, full heap
      push_req(efla_pkg::REQ_ALLOC, 0, 0);
      push_req(efla_pkg::REQ_ALLOC, 4095, 0);
      push_req(efla_pkg::REQ_ALLOC, 1025, 0);
      push_req(efla_pkg::REQ_ALLOC, 1, 0);
      push_req(efla_pkg::REQ_ALLOC, 13, 0);
      push_req(efla_pkg::REQ_ALLOC, 100, 0);
      push_req(efla_pkg::REQ_FREE, 3, 0);
      push_req(efla_pkg::REQ_FREE, 0, 0);
      push_req(efla_pkg::REQ_FREE, 1020, 0);
      push_req(efla_pkg::REQ_FREE, 1023, 0);
      push_req(efla_pkg::REQ_FREE, 8, 0);
      push_req(efla_pkg::REQ_FREE, 12, 0);
      push_req(efla_pkg::REQ_FREE, 4, 0);
      push_req(efla_pkg::REQ_FREE, 4, 0);
      push_req(2'd3, 4095, 1023);
      push_req(efla_pkg::REQ_CONS, 0, 0);
      push_req(efla_pkg::REQ_ALLOC, 1020, 0);
      push_req(efla_pkg::REQ_ALLOC, 1016, 0);
      push_req(efla_pkg::REQ_ALLOC, 4, 0);
      push_req(efla_pkg::REQ_FREE, 4, 0);
      push_req(efla_pkg::REQ_CONS, 0, 0);
      push_req(efla_pkg::REQ_ALLOC, 1024, 0);
      push_req(efla_pkg::REQ_FREE, 1016, 0);

      // random: mostly alloc/free of plausible blocks, some noise
      for (k = 0; k < N_RANDOM; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            push_req(efla_pkg::REQ_ALLOC, ($urandom_range(0, 9) == 0)
                     ? $urandom_range(0, 4095) : $urandom_range(1, 96), 0);
         end else if (pick < 80) begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                  : $urandom_range(1, 254) * 4;
            push_req(efla_pkg::REQ_FREE, $urandom_range(0, 4095), idx);
         end else if (pick < 92) begin
            push_req(efla_pkg::REQ_CONS, $urandom_range(0, 4095), $urandom_range(0, 1023));
         end else begin
            code = 2'($urandom_range(0, 3));
            push_req(code, $urandom_range(0, 4095), $urandom_range(0, 1023));
         end
      end

      // last stretch runs without idling
      wait (pending_reqs.size() < 100);
      quiet = 1'b1;
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
hdl/efla_pkg.sv
hdl/efla_ram.sv
hdl/efla_engine.sv
hdl/explicit_free_list_allocator_top.sv
tb/tb_explicit_free_list_allocator_top.sv
